// ----- hdl/wctc_pkg.sv -----
// Shared types and constants for the write-back cache tag controller.
// Holds the request and response word layouts and the default geometry.
// Depends on nothing.
`timescale 1ns / 1ps

package wctc_pkg;

   localparam int ADDR_W    = 64;
   localparam int WAY_OUT_W = 3;

   localparam int SETS_DEFAULT        = 256;
   localparam int WAYS_DEFAULT        = 8;
   localparam int BLOCK_BYTES_DEFAULT = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 fill_needed;
      logic [ADDR_W-1:0]    fill_address;
      logic                 writeback_needed;
      logic [ADDR_W-1:0]    victim_address;
   } rsp_type;

endpackage

// ----- hdl/wctc_tag_ram.sv -----
// Tag memory: one row per set holding valid, dirty, LRU rank and tag of every way.
// One write port and one registered read port. Depends on nothing.
`timescale 1ns / 1ps

module wctc_tag_ram #(
   parameter int DEPTH = 256,
   parameter int ROW_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [ROW_W-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [ROW_W-1:0]         rd_data
);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // The read register holds its value until the next read.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/wctc_lookup.sv -----
// Hit detection, victim choice and LRU update for one set row.
// Produces the row to write back and the response word. Depends on wctc_pkg.
`timescale 1ns / 1ps

module wctc_lookup #(
   parameter int SETS        = 256,
   parameter int WAYS        = 8,
   parameter int BLOCK_BYTES = 32,
   parameter int ROW_W       = 8
) (
   input  wctc_pkg::req_type req,
   input  logic [ROW_W-1:0]  row_in,
   output logic [ROW_W-1:0]  row_out,
   output wctc_pkg::rsp_type rsp
);
   import wctc_pkg::*;

   localparam int OFF_BITS = $clog2(BLOCK_BYTES);
   localparam int SET_BITS = $clog2(SETS);
   localparam int TAG_W    = ADDR_W - OFF_BITS - SET_BITS;
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int AGE_W    = $clog2(WAYS);
   localparam int ENTRY_W  = TAG_W + AGE_W + 2;

   logic [TAG_W-1:0]    ent_tag   [WAYS];
   logic [AGE_W-1:0]    ent_age   [WAYS];
   logic                ent_dirty [WAYS];
   logic                ent_valid [WAYS];

   logic [TAG_W-1:0]    req_tag;
   logic [SET_BITS-1:0] req_set;
   logic                is_store;

   logic                found;
   logic [WAY_BITS-1:0] hit_way;
   logic                free_found;
   logic [WAY_BITS-1:0] free_way;
   logic [AGE_W-1:0]    best_age;
   logic [WAY_BITS-1:0] vic_way;
   logic [WAY_BITS-1:0] sel_way;
   logic [AGE_W:0]      old_rank;
   logic                wb;

   assign req_tag  = req.address[ADDR_W-1 -: TAG_W];
   assign req_set  = req.address[OFF_BITS +: SET_BITS];
   assign is_store = (req.opcode == OP_STORE);

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         ent_tag[i]   = row_in[i*ENTRY_W +: TAG_W];
         ent_age[i]   = row_in[i*ENTRY_W + TAG_W +: AGE_W];
         ent_dirty[i] = row_in[i*ENTRY_W + TAG_W + AGE_W];
         ent_valid[i] = row_in[i*ENTRY_W + TAG_W + AGE_W + 1];
      end
   end

   // Priority searches: scanning downward lets the lowest way win.
   always_comb begin
      found      = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (ent_valid[i] && ent_tag[i] == req_tag) begin
            found   = 1'b1;
            hit_way = WAY_BITS'(i);
         end
         if (!ent_valid[i]) begin
            free_found = 1'b1;
            free_way   = WAY_BITS'(i);
         end
      end
   end

   // Oldest line of a full set; strict compare keeps the lowest way on a tie.
   always_comb begin
      best_age = '0;
      vic_way  = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (ent_age[i] > best_age) begin
            best_age = ent_age[i];
            vic_way  = WAY_BITS'(i);
         end
      end
   end

   always_comb begin
      priority if (found) begin
         sel_way  = hit_way;
         old_rank = {1'b0, ent_age[hit_way]};
      end else if (free_found) begin
         sel_way  = free_way;
         old_rank = (AGE_W+1)'(WAYS);
      end else begin
         sel_way  = vic_way;
         old_rank = {1'b0, ent_age[vic_way]};
      end
   end

   assign wb = !found && !free_found && ent_dirty[vic_way];

   always_comb begin
      row_out = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_BITS'(i) == sel_way) begin
            row_out[i*ENTRY_W +: TAG_W]         = found ? ent_tag[i] : req_tag;
            row_out[i*ENTRY_W + TAG_W +: AGE_W] = '0;
            row_out[i*ENTRY_W + TAG_W + AGE_W]  = found ? (ent_dirty[i] | is_store)
                                                        : is_store;
            row_out[i*ENTRY_W + TAG_W + AGE_W + 1] = 1'b1;
         end else begin
            row_out[i*ENTRY_W +: TAG_W] = ent_tag[i];
            if (ent_valid[i] && {1'b0, ent_age[i]} < old_rank) begin
               row_out[i*ENTRY_W + TAG_W +: AGE_W] = AGE_W'(ent_age[i] + 1'b1);
            end else begin
               row_out[i*ENTRY_W + TAG_W +: AGE_W] = ent_age[i];
            end
            row_out[i*ENTRY_W + TAG_W + AGE_W]     = ent_dirty[i];
            row_out[i*ENTRY_W + TAG_W + AGE_W + 1] = ent_valid[i];
         end
      end
   end

   always_comb begin
      rsp.hit              = found;
      rsp.way              = WAY_OUT_W'(sel_way);
      rsp.fill_needed      = !found;
      rsp.fill_address     = found ? '0
                                   : {req.address[ADDR_W-1:OFF_BITS], {OFF_BITS{1'b0}}};
      rsp.writeback_needed = wb;
      rsp.victim_address   = wb ? {ent_tag[vic_way], req_set, {OFF_BITS{1'b0}}} : '0;
   end

endmodule

// ----- hdl/writeback_cache_tag_controller_unit.sv -----
// Top level of the write-back cache tag controller: control sequencer,
// tag memory and lookup logic. Depends on wctc_pkg, wctc_tag_ram, wctc_lookup.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one access
//   word: opcode (load or store) and 64-bit byte address. The response
//   channel (rsp_valid, rsp_stall, rsp_data) returns one word per access:
//   hit, way, fill request with block address, and write-back request with
//   the victim block address.
//   Each access reads the set row from the tag memory, then evaluates it,
//   writes the updated row back and loads the response register. The
//   read-modify-write of the tag memory is not overlapped: no new request
//   is taken until the previous one has written its row back.
//   After reset the controller sweeps the tag memory clearing one set per
//   cycle, all SETS sets (256 by default), with req_stall held high.
//   The response sits in an output register; a new request may be read while
//   the receiver stalls, but its row is not updated until that register
//   frees up. Geometry parameters must be powers of two.
`timescale 1ns / 1ps

module writeback_cache_tag_controller_unit #(
   parameter int SETS        = wctc_pkg::SETS_DEFAULT,
   parameter int WAYS        = wctc_pkg::WAYS_DEFAULT,
   parameter int BLOCK_BYTES = wctc_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wctc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wctc_pkg::rsp_type rsp_data
);
   import wctc_pkg::*;

   localparam int OFF_BITS = $clog2(BLOCK_BYTES);
   localparam int SET_BITS = $clog2(SETS);
   localparam int TAG_W    = ADDR_W - OFF_BITS - SET_BITS;
   localparam int AGE_W    = $clog2(WAYS);
   localparam int ENTRY_W  = TAG_W + AGE_W + 2;
   localparam int ROW_W    = WAYS * ENTRY_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type           state_ff, state_in;
   logic [SET_BITS-1:0] clear_idx_ff, clear_idx_in;
   req_type             req_ff, req_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_accept;
   logic                out_free;
   logic                commit;
   logic                mem_wr_en;
   logic [SET_BITS-1:0] mem_wr_addr;
   logic [ROW_W-1:0]    mem_wr_data;
   logic [ROW_W-1:0]    row_rd;
   logic [ROW_W-1:0]    row_new;
   rsp_type             lookup_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff == ST_LOOKUP) && out_free;

   assign mem_wr_en   = (state_ff == ST_CLEAR) || commit;
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clear_idx_ff
                                               : req_ff.address[OFF_BITS +: SET_BITS];
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : row_new;

   wctc_tag_ram #(
      .DEPTH (SETS),
      .ROW_W (ROW_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_data.address[OFF_BITS +: SET_BITS]),
      .rd_data (row_rd)
   );

   wctc_lookup #(
      .SETS        (SETS),
      .WAYS        (WAYS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .ROW_W       (ROW_W)
   ) u_lookup (
      .req     (req_ff),
      .row_in  (row_rd),
      .row_out (row_new),
      .rsp     (lookup_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == SET_BITS'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // The row write lands before the next read can be issued, so
            // consecutive accesses to one set always see fresh state.
            if (out_free) begin
               rsp_in       = lookup_rsp;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
